FILE: rtl/core/longest_balanced_bracket_run_defines.svh
// ----------------------------------------------------------------------------
// Longest balanced bracket run: assertion macros
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef LONGEST_BALANCED_BRACKET_RUN_DEFINES_SVH
`define LONGEST_BALANCED_BRACKET_RUN_DEFINES_SVH

// Checked on every clock edge outside reset.
`define LBBR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LBBR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/lbbr_pkg.sv
// ----------------------------------------------------------------------------
// Longest balanced bracket run: package
// Widths, bracket codes, stack entry type and symbol decoder.
// ----------------------------------------------------------------------------
package lbbr_pkg;

  localparam int MAX_LEN_DEF = 4096;
  localparam int COUNT_W     = 13;
  localparam int KIND_W      = 2;

  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [COUNT_W+1:0] sum_t;  // two full counts plus two
  typedef logic [KIND_W-1:0]  kind_t;

  localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

  localparam kind_t KIND_PAREN   = 2'd0;
  localparam kind_t KIND_SQUARE  = 2'd1;
  localparam kind_t KIND_CURLY   = 2'd2;
  localparam kind_t KIND_ANGLE   = 2'd3;

  localparam logic [7:0] CH_LPAREN = 8'h28;  // (
  localparam logic [7:0] CH_RPAREN = 8'h29;  // )
  localparam logic [7:0] CH_LSQR   = 8'h5B;  // [
  localparam logic [7:0] CH_RSQR   = 8'h5D;  // ]
  localparam logic [7:0] CH_LCURL  = 8'h7B;  // {
  localparam logic [7:0] CH_RCURL  = 8'h7D;  // }
  localparam logic [7:0] CH_LANGLE = 8'h3C;  // <
  localparam logic [7:0] CH_RANGLE = 8'h3E;  // >

  typedef struct packed {
    kind_t  kind;
    count_t saved;
  } entry_t;

  typedef struct packed {
    logic  is_open;
    logic  is_close;
    kind_t kind;
  } sym_class_t;

  function automatic sym_class_t classify(input logic [7:0] sym);
    sym_class_t c;
    c = '0;
    unique case (sym)
      CH_LPAREN: begin c.is_open  = 1'b1; c.kind = KIND_PAREN;  end
      CH_RPAREN: begin c.is_close = 1'b1; c.kind = KIND_PAREN;  end
      CH_LSQR:   begin c.is_open  = 1'b1; c.kind = KIND_SQUARE; end
      CH_RSQR:   begin c.is_close = 1'b1; c.kind = KIND_SQUARE; end
      CH_LCURL:  begin c.is_open  = 1'b1; c.kind = KIND_CURLY;  end
      CH_RCURL:  begin c.is_close = 1'b1; c.kind = KIND_CURLY;  end
      CH_LANGLE: begin c.is_open  = 1'b1; c.kind = KIND_ANGLE;  end
      CH_RANGLE: begin c.is_close = 1'b1; c.kind = KIND_ANGLE;  end
      default:   c = '0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/longest_balanced_bracket_run.sv
// ----------------------------------------------------------------------------
// Longest balanced bracket run
// Scans a string last character first and, per position, reports the length
// of the longest balanced run over (), [], {} and <> starting there.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | beat payload
//  --------+---------------------+-------------------------------
//  in      | in_valid / in_stall | start_req, symbol
//  out     | out_valid/out_stall | run_length, overflow
//
// One beat per clock while in_stall is low; each input beat yields one output
// beat in the next cycle from the output register. The limit is the stack RAM:
// one push or pop per beat, top entry cached in a register.
// Reset clears the level, count, bypass flag and output valid only; the stack
// RAM is never cleared, so there is no clearing pass.
// in_stall is high only while a result waits in the output register and the
// consumer stalls it.
//
// Stack layout: the top entry (index level-1) lives in register "top"; the
// RAM holds indices 0..level-2. Every cycle the RAM reads index next_level-2
// so the entry below the top is ready for a pop on the next beat. A push
// writes the old top to index level-1, which is the same index being read;
// a one-entry bypass forwards that write.
// ----------------------------------------------------------------------------
module longest_balanced_bracket_run #(
  parameter int MAX_LEN = lbbr_pkg::MAX_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         start_req,
  input  logic [7:0]                   symbol,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lbbr_pkg::COUNT_W-1:0] run_length,
  output logic                         overflow
);

  localparam int LVL_W  = $clog2(MAX_LEN + 1);
  localparam int ADDR_W = $clog2(MAX_LEN);

  typedef logic [LVL_W-1:0] lvl_t;

  // Architectural state
  lvl_t             level;
  lbbr_pkg::count_t count;
  lbbr_pkg::entry_t top;

  // RAM side
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  lbbr_pkg::entry_t  ram_rdata;
  logic              byp;
  lbbr_pkg::entry_t  byp_data;
  lbbr_pkg::entry_t  second;

  // Per-beat logic
  logic                 accept;
  lbbr_pkg::sym_class_t cls;
  lvl_t                 lvl_cur;
  lvl_t                 lvl_m1;
  lvl_t                 rd_lvl;
  lvl_t                 rd_m2;
  lbbr_pkg::count_t     cnt_cur;
  lvl_t                 level_next;
  lbbr_pkg::count_t     count_next;
  lbbr_pkg::entry_t     top_next;
  logic                 push_we;
  lbbr_pkg::sum_t       sum;
  lbbr_pkg::count_t     len;
  logic                 ovf;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign cls      = lbbr_pkg::classify(symbol);
  assign second   = byp ? byp_data : ram_rdata;

  assign lvl_cur = start_req ? '0 : level;
  assign cnt_cur = start_req ? '0 : count;
  assign lvl_m1  = lvl_cur - lvl_t'(1);
  assign sum     = {2'b00, cnt_cur} + {2'b00, top.saved} + lbbr_pkg::sum_t'(2);

  always_comb begin
    level_next = lvl_cur;
    count_next = cnt_cur;
    top_next   = top;
    push_we    = 1'b0;
    len        = '0;
    ovf        = 1'b0;
    unique if (cls.is_close) begin
      if (lvl_cur < lvl_t'(MAX_LEN)) begin
        push_we    = (lvl_cur != '0);  // old top goes down into the RAM
        top_next   = '{kind: cls.kind, saved: cnt_cur};
        level_next = lvl_cur + lvl_t'(1);
      end else begin
        ovf = 1'b1;  // full stack: push dropped
      end
      count_next = '0;
    end else if (cls.is_open) begin
      if (lvl_cur == '0) begin
        count_next = '0;
      end else if (top.kind != cls.kind) begin
        // mismatched opener empties the stack
        level_next = '0;
        count_next = '0;
      end else begin
        level_next = lvl_m1;
        top_next   = second;
        if (sum > lbbr_pkg::sum_t'(lbbr_pkg::COUNT_MAX)) begin
          count_next = lbbr_pkg::COUNT_MAX;
          ovf        = 1'b1;
        end else begin
          count_next = sum[lbbr_pkg::COUNT_W-1:0];
        end
        len = count_next;
      end
    end else begin
      // other bytes keep the state, after a restart if one is requested
      level_next = lvl_cur;
      count_next = cnt_cur;
    end
  end

  // Prefetch the entry below the top of the state after this cycle.
  assign rd_lvl    = accept ? level_next : level;
  assign rd_m2     = rd_lvl - lvl_t'(2);
  assign ram_raddr = rd_m2[ADDR_W-1:0];
  assign ram_waddr = lvl_m1[ADDR_W-1:0];
  assign ram_we    = accept && push_we;

  lbbr_ram #(
    .WIDTH ($bits(lbbr_pkg::entry_t)),
    .DEPTH (MAX_LEN)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (top),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= '0;
      count     <= '0;
      byp       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      byp <= ram_we && (ram_waddr == ram_raddr);
      if (accept) begin
        level     <= level_next;
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byp_data <= top;
    if (accept) begin
      top        <= top_next;
      run_length <= len;
      overflow   <= ovf;
    end
  end

endmodule

FILE: rtl/core/lbbr_ram.sv
// ----------------------------------------------------------------------------
// Longest balanced bracket run: generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lbbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/lbbr_checker.sv
// ----------------------------------------------------------------------------
// Longest balanced bracket run: port checker
// Port-level properties of the top level, bound to every instance.
// ----------------------------------------------------------------------------
`include "longest_balanced_bracket_run_defines.svh"

module lbbr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         start_req,
  input logic [7:0]                   symbol,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [lbbr_pkg::COUNT_W-1:0] run_length,
  input logic                         overflow
);

  logic                 in_acc;
  lbbr_pkg::sym_class_t cls;

  assign in_acc = in_valid && !in_stall;
  assign cls    = lbbr_pkg::classify(symbol);

  `LBBR_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")

  `LBBR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(run_length) && $stable(overflow), "stalled output beat changed")

  `LBBR_ASSERT(a_plain_zero, in_acc && !cls.is_open && !cls.is_close |=> out_valid && run_length == '0 && !overflow, "non-bracket beat gave a result")

  `LBBR_ASSERT(a_fresh_open, in_acc && start_req && cls.is_open |=> out_valid && run_length == '0 && !overflow, "opener on a fresh string matched")

  `LBBR_ASSERT(a_even_len, out_valid && run_length[0] |-> run_length == lbbr_pkg::COUNT_MAX && overflow, "odd run length without saturation")

endmodule

bind longest_balanced_bracket_run lbbr_checker u_lbbr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .start_req  (start_req),
  .symbol     (symbol),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .run_length (run_length),
  .overflow   (overflow)
);
